/* rtl/npr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package npr_pkg;

  // Coordinate and angle formats.
  localparam int COORD_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int DIST_BITS    = 2 * COORD_BITS;
  localparam int ATAN_LEN     = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int STEPS_TOTAL  = (COORD_BITS > CORDIC_ITERS) ? COORD_BITS : CORDIC_ITERS;
  localparam int CNT_W        = $clog2(STEPS_TOTAL);

  // The vector is scaled by 2^16 and grows by the CORDIC gain on top of that.
  localparam int CORDIC_W     = COORD_BITS + 20;
  localparam int ANGLE_SHIFT  = 32 - ANGLE_BITS;
  localparam int SQRT_REM_W   = COORD_BITS + 3;

  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         point_valid;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic                         found;
    logic        [COORD_BITS-1:0] range_mm;
    logic signed [ANGLE_BITS-1:0] bearing;
  } result_t;

  // One closed cloud, handed from the front end to the back end.
  typedef struct packed {
    logic                         found;
    logic        [DIST_BITS-1:0]  dist_sq;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } job_t;

  // atan(2^-i) in units of pi / 2^31, rounded to nearest.
  function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      ATAN_IDX_W'(0):  v = 32'h20000000;
      ATAN_IDX_W'(1):  v = 32'h12E4051E;
      ATAN_IDX_W'(2):  v = 32'h09FB385B;
      ATAN_IDX_W'(3):  v = 32'h051111D4;
      ATAN_IDX_W'(4):  v = 32'h028B0D43;
      ATAN_IDX_W'(5):  v = 32'h0145D7E1;
      ATAN_IDX_W'(6):  v = 32'h00A2F61E;
      ATAN_IDX_W'(7):  v = 32'h00517C55;
      ATAN_IDX_W'(8):  v = 32'h0028BE53;
      ATAN_IDX_W'(9):  v = 32'h00145F2F;
      ATAN_IDX_W'(10): v = 32'h000A2F98;
      ATAN_IDX_W'(11): v = 32'h000517CC;
      ATAN_IDX_W'(12): v = 32'h00028BE6;
      ATAN_IDX_W'(13): v = 32'h000145F3;
      ATAN_IDX_W'(14): v = 32'h0000A2FA;
      ATAN_IDX_W'(15): v = 32'h0000517D;
      ATAN_IDX_W'(16): v = 32'h000028BE;
      ATAN_IDX_W'(17): v = 32'h0000145F;
      ATAN_IDX_W'(18): v = 32'h00000A30;
      ATAN_IDX_W'(19): v = 32'h00000518;
      ATAN_IDX_W'(20): v = 32'h0000028C;
      ATAN_IDX_W'(21): v = 32'h00000146;
      ATAN_IDX_W'(22): v = 32'h000000A3;
      ATAN_IDX_W'(23): v = 32'h00000051;
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/nearest_point_range_bearing.sv */
`timescale 1ns / 1ps
`default_nettype none

// Nearest point, range and bearing. Points of a cloud are pushed in one per transfer, in robot
// frame millimetres; points whose point_valid bit is low are skipped, and the point with
// last_point set closes the cloud. Each cloud yields exactly one result, popped from the result
// side: found, the floor square root of the smallest squared distance in millimetres, and the
// atan2 bearing of that point in units of pi/32768 radians, with a bearing of pi reading as
// -32768. On a tie in distance the earliest point is kept. A cloud with no valid point gives
// found low and zeros elsewhere. The front end takes one point every clock cycle while full is
// low: it squares the coordinates in one registered stage and compares against the running
// minimum in the next. A closed cloud goes into a two-entry queue, and the back end works it
// off with the bit-serial square root and the CORDIC unit, which step together once per cycle.
// The front end only holds off new points when a cloud end finds that queue full, so clouds of
// a few dozen points or more stream through without a stall while results are popped in time.
// A finished result sits in an output register, so the back end may start on the next cloud
// while it waits to be popped.
module nearest_point_range_bearing import npr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire point_t point,
  output logic        empty,
  input  wire logic   pop,
  output result_t     result
);

  job_t f_job, q_job;
  logic f_push, q_full, q_empty, q_pop;

  // Front end: running minimum over the points of the current cloud.
  npr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .point    (point),
    .job_push (f_push),
    .job      (f_job),
    .job_full (q_full)
  );

  // Queue of closed clouds between the two halves.
  npr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_job),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_job),
    .empty   (q_empty)
  );

  // Back end: square root and CORDIC bearing, then the output register.
  npr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

/* rtl/npr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module npr_front import npr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire point_t point,
  output logic        job_push,
  output job_t        job,
  input  wire logic   job_full
);

  logic        [COORD_BITS-1:0] ux, uy, ax, ay;
  logic        [DIST_BITS-1:0]  sqx, sqy;

  logic                         a_valid;
  logic signed [COORD_BITS-1:0] a_x, a_y;
  logic                         a_pv, a_last;
  logic        [DIST_BITS-1:0]  a_sqx, a_sqy;
  logic                         a_go, accept;

  logic        [DIST_BITS-1:0]  dist_now;
  logic                         take;

  logic                         have_point;
  logic        [DIST_BITS-1:0]  best_dist_sq;
  logic signed [COORD_BITS-1:0] best_x, best_y;

  assign ux = point.point_x;
  assign uy = point.point_y;
  assign ax = point.point_x[COORD_BITS-1] ? (~ux + 1'b1) : ux;
  assign ay = point.point_y[COORD_BITS-1] ? (~uy + 1'b1) : uy;
  assign sqx = ax * ax;
  assign sqy = ay * ay;

  // The squared stage only stalls when it holds a cloud end and the queue is full.
  assign a_go   = a_valid && !(a_last && job_full);
  assign full   = a_valid && !a_go;
  assign accept = push && !full;

  assign dist_now = a_sqx + a_sqy;
  assign take     = a_pv && (!have_point || (dist_now < best_dist_sq));

  assign job_push    = a_go && a_last;
  assign job.found   = have_point || take;
  assign job.dist_sq = take ? dist_now : best_dist_sq;
  assign job.x       = take ? a_x  : best_x;
  assign job.y       = take ? a_y  : best_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept || (a_valid && !a_go);
    end
    if (accept) begin
      a_x    <= point.point_x;
      a_y    <= point.point_y;
      a_pv   <= point.point_valid;
      a_last <= point.last_point;
      a_sqx  <= sqx;
      a_sqy  <= sqy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      have_point   <= 1'b0;
      best_dist_sq <= '1;
      best_x       <= '0;
      best_y       <= '0;
    end else if (a_go && take) begin
      have_point   <= 1'b1;
      best_dist_sq <= dist_now;
      best_x       <= a_x;
      best_y       <= a_y;
    end
  end

endmodule

`default_nettype wire

/* rtl/npr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module npr_queue import npr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd,
  output job_t      rd_data,
  output logic      empty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign full    = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/npr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module npr_back import npr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_empty,
  output logic      job_pop,
  output result_t   result,
  output logic      empty,
  input  wire logic pop
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                       state;
  logic        [CNT_W-1:0]      cnt;
  logic                         found;

  logic        [DIST_BITS-1:0]  rad;
  logic        [SQRT_REM_W-1:0] rem;
  logic        [COORD_BITS-1:0] root;

  logic                         skip;
  logic signed [CORDIC_W-1:0]   cx, cy;
  logic        [31:0]           z;

  logic                         res_valid;
  result_t                      res;

  // Square root step: one result bit per cycle.
  logic                         sq_on;
  logic        [SQRT_REM_W-1:0] rem_sh, trial;
  logic                         sq_ge;

  // CORDIC vectoring step.
  logic                         co_on;
  logic signed [CORDIC_W-1:0]   dx, dy;
  logic        [31:0]           atan_i;

  // Job set-up.
  logic signed [CORDIC_W-1:0]   jx, jy;
  logic                         j_yzero, j_xneg;

  logic        [31:0]           z_rnd;
  logic                         last_step, res_free;

  assign sq_on  = {1'b0, cnt} < (CNT_W + 1)'(COORD_BITS);
  assign rem_sh = {rem[SQRT_REM_W-3:0], rad[DIST_BITS-1 -: 2]};
  assign trial  = SQRT_REM_W'({root, 2'b01});
  assign sq_ge  = rem_sh >= trial;

  assign co_on  = !skip && ({1'b0, cnt} < (CNT_W + 1)'(CORDIC_ITERS));
  assign dx     = cy >>> cnt;
  assign dy     = cx >>> cnt;
  assign atan_i = atan_entry(ATAN_IDX_W'(cnt));

  assign jx      = {{4{job.x[COORD_BITS-1]}}, job.x, 16'b0};
  assign jy      = {{4{job.y[COORD_BITS-1]}}, job.y, 16'b0};
  assign j_yzero = (job.y == '0);
  assign j_xneg  = job.x[COORD_BITS-1];

  assign z_rnd     = z + (32'd1 << (ANGLE_SHIFT - 1));
  assign last_step = (cnt == CNT_W'(STEPS_TOTAL - 1));
  assign res_free  = !res_valid || pop;

  assign job_pop = (state == ST_IDLE) && !job_empty;
  assign result  = res;
  assign empty   = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if ((state == ST_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_step) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // Datapath registers carry no reset.
    unique case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          found <= job.found;
          rad   <= job.dist_sq;
          rem   <= '0;
          root  <= '0;
          skip  <= j_yzero;
          if (j_yzero) begin
            z  <= j_xneg ? 32'h80000000 : 32'h0;
            cx <= jx;
            cy <= jy;
          end else if (j_xneg) begin
            // Either half-turn, +pi or -pi, is the same word modulo 2^32.
            z  <= 32'h80000000;
            cx <= -jx;
            cy <= -jy;
          end else begin
            z  <= 32'h0;
            cx <= jx;
            cy <= jy;
          end
        end
      end
      ST_RUN: begin
        if (sq_on) begin
          rad  <= rad << 2;
          rem  <= sq_ge ? (rem_sh - trial) : rem_sh;
          root <= {root[COORD_BITS-2:0], sq_ge};
        end
        if (co_on) begin
          if (!cy[CORDIC_W-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + atan_i;
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - atan_i;
          end
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res.found    <= found;
          res.range_mm <= found ? root : '0;
          res.bearing  <= found ? z_rnd[31 -: ANGLE_BITS] : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
